FILE: sv/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// Shared types and constants for the SHA-1 message digest engine.
// ----------------------------------------------------------------------------
package sha1md_pkg;

  localparam int WordWidth   = 32;
  localparam int NumChain    = 5;
  localparam int WindowDepth = 16;
  localparam int NumRounds   = 80;
  localparam int FillWidth   = 6;
  localparam int RoundWidth  = 7;
  localparam int CountWidth  = 64;

  localparam logic [WordWidth-1:0] IV0 = 32'h67452301;
  localparam logic [WordWidth-1:0] IV1 = 32'hEFCDAB89;
  localparam logic [WordWidth-1:0] IV2 = 32'h98BADCFE;
  localparam logic [WordWidth-1:0] IV3 = 32'h10325476;
  localparam logic [WordWidth-1:0] IV4 = 32'hC3D2E1F0;

  localparam logic [WordWidth-1:0] K0 = 32'h5A827999;
  localparam logic [WordWidth-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordWidth-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordWidth-1:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Fill positions that steer the padding sequence
  localparam logic [FillWidth-1:0] FILL_LAST = 6'd63;
  localparam logic [FillWidth-1:0] FILL_LEN  = 6'd56;

  localparam logic [RoundWidth-1:0] ROUND_LAST = 7'd79;
  localparam logic [RoundWidth-1:0] ROUND_F1   = 7'd20;
  localparam logic [RoundWidth-1:0] ROUND_F2   = 7'd40;
  localparam logic [RoundWidth-1:0] ROUND_F3   = 7'd60;

  // Source of the byte written into the block buffer
  localparam logic [1:0] SEL_DATA = 2'd0;
  localparam logic [1:0] SEL_PAD  = 2'd1;
  localparam logic [1:0] SEL_ZERO = 2'd2;
  localparam logic [1:0] SEL_LEN  = 2'd3;

  typedef struct packed {
    logic       put_byte;
    logic [1:0] byte_sel;
    logic       count_inc;
    logic       round_step;
    logic       chain_add;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic [FillWidth-1:0] fill;
    logic                 round_last;
    logic                 out_busy;
  } status_t;

endpackage

FILE: sv/sha1md_ctrl.sv
// ----------------------------------------------------------------------------
// sha1md_ctrl
// Sequencer: takes items, walks the padding, runs the 80 rounds and hands
// the digest to the output register.
// ----------------------------------------------------------------------------
module sha1md_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                byte_present,
  input  logic                last_byte,
  output logic                in_stall,
  input  sha1md_pkg::status_t status,
  output sha1md_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAD   = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FINAL = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       last_pending;
  logic       pad_first;
  logic       pad_wrap;
  logic       pad_done;
  logic       accept;
  logic       fill_full;
  logic       fill_tail;
  logic [1:0] pad_sel;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign fill_full = (status.fill == sha1md_pkg::FILL_LAST);
  assign fill_tail = (status.fill >= sha1md_pkg::FILL_LEN);

  always_comb begin
    if (pad_first) begin
      pad_sel = sha1md_pkg::SEL_PAD;
    end else if (!pad_wrap && fill_tail) begin
      pad_sel = sha1md_pkg::SEL_LEN;
    end else begin
      pad_sel = sha1md_pkg::SEL_ZERO;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.put_byte  = byte_present;
          cmd.count_inc = byte_present;
          cmd.byte_sel  = sha1md_pkg::SEL_DATA;
          if (byte_present && fill_full) begin
            state_next = ST_ROUND;
          end else if (last_byte) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd.put_byte = 1'b1;
        cmd.byte_sel = pad_sel;
        if (fill_full) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        if (status.round_last) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd.chain_add = 1'b1;
        if (pad_done) begin
          state_next = ST_EMIT;
        end else if (last_pending) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      last_pending <= 1'b0;
      pad_first    <= 1'b0;
      pad_wrap     <= 1'b0;
      pad_done     <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        last_pending <= last_byte;
        pad_first    <= 1'b1;
        pad_wrap     <= 1'b0;
        pad_done     <= 1'b0;
      end else if (state == ST_PAD) begin
        pad_first <= 1'b0;
        if (fill_full) begin
          pad_wrap <= 1'b0;
          pad_done <= (pad_sel == sha1md_pkg::SEL_LEN);
        end else if (pad_first && fill_tail) begin
          // no room for the length: zero out this block, length goes in the next
          pad_wrap <= 1'b1;
        end
      end else if (cmd.emit) begin
        last_pending <= 1'b0;
        pad_done     <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/sha1md_dp.sv
// ----------------------------------------------------------------------------
// sha1md_dp
// Datapath: byte packer, 16-word schedule shift line, one SHA-1 round per
// cycle, chaining words, byte count and the digest output register.
// ----------------------------------------------------------------------------
module sha1md_dp (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          data_byte,
  input  sha1md_pkg::cmd_t    cmd,
  output sha1md_pkg::status_t status,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [31:0]         digest_word_0,
  output logic [31:0]         digest_word_1,
  output logic [31:0]         digest_word_2,
  output logic [31:0]         digest_word_3,
  output logic [31:0]         digest_word_4
);

  localparam int WW = sha1md_pkg::WordWidth;

  logic [WW-1:0] window [sha1md_pkg::WindowDepth];
  logic [WW-1:0] chain  [sha1md_pkg::NumChain];
  logic [WW-1:0] va, vb, vc, vd, ve;
  logic [23:0]   acc;
  logic [sha1md_pkg::FillWidth-1:0]  fill;
  logic [sha1md_pkg::RoundWidth-1:0] round_index;
  logic [sha1md_pkg::CountWidth-1:0] byte_count;

  logic [7:0]    byte_in;
  logic [WW-1:0] word_in;
  logic [sha1md_pkg::CountWidth-1:0] bit_len;
  logic [5:0]    len_lsb;
  logic [WW-1:0] sched_x;
  logic [WW-1:0] sched_new;
  logic [WW-1:0] f_val;
  logic [WW-1:0] k_val;
  logic [WW-1:0] temp;

  assign bit_len = {byte_count[sha1md_pkg::CountWidth-4:0], 3'b000};
  assign len_lsb = {~fill[2:0], 3'b000};

  always_comb begin
    case (cmd.byte_sel)
      sha1md_pkg::SEL_DATA: byte_in = data_byte;
      sha1md_pkg::SEL_PAD:  byte_in = sha1md_pkg::PAD_BYTE;
      sha1md_pkg::SEL_LEN:  byte_in = bit_len[len_lsb +: 8];
      default:              byte_in = 8'h00;
    endcase
  end

  assign word_in = {acc, byte_in};

  // W[t+16] from the window holding W[t..t+15]
  assign sched_x   = window[13] ^ window[8] ^ window[2] ^ window[0];
  assign sched_new = {sched_x[WW-2:0], sched_x[WW-1]};

  always_comb begin
    if (round_index < sha1md_pkg::ROUND_F1) begin
      f_val = (vb & vc) | (~vb & vd);
      k_val = sha1md_pkg::K0;
    end else if (round_index < sha1md_pkg::ROUND_F2) begin
      f_val = vb ^ vc ^ vd;
      k_val = sha1md_pkg::K1;
    end else if (round_index < sha1md_pkg::ROUND_F3) begin
      f_val = (vb & vc) | (vb & vd) | (vc & vd);
      k_val = sha1md_pkg::K2;
    end else begin
      f_val = vb ^ vc ^ vd;
      k_val = sha1md_pkg::K3;
    end
  end

  assign temp = {va[WW-6:0], va[WW-1:WW-5]} + f_val + ve + k_val + window[0];

  assign status.fill       = fill;
  assign status.round_last = (round_index == sha1md_pkg::ROUND_LAST);
  assign status.out_busy   = out_valid && out_stall;

  // Schedule window, working variables and output payload
  always_ff @(posedge clk) begin
    if (cmd.put_byte) begin
      acc <= word_in[23:0];
      if (fill[1:0] == 2'b11) begin
        for (int i = 0; i < sha1md_pkg::WindowDepth - 1; i++) begin
          window[i] <= window[i+1];
        end
        window[sha1md_pkg::WindowDepth-1] <= word_in;
      end
      if (fill == sha1md_pkg::FILL_LAST) begin
        va <= chain[0];
        vb <= chain[1];
        vc <= chain[2];
        vd <= chain[3];
        ve <= chain[4];
      end
    end else if (cmd.round_step) begin
      for (int i = 0; i < sha1md_pkg::WindowDepth - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[sha1md_pkg::WindowDepth-1] <= sched_new;
      va <= temp;
      vb <= va;
      vc <= {vb[1:0], vb[WW-1:2]};
      vd <= vc;
      ve <= vd;
    end
    if (cmd.emit) begin
      digest_word_0 <= chain[0];
      digest_word_1 <= chain[1];
      digest_word_2 <= chain[2];
      digest_word_3 <= chain[3];
      digest_word_4 <= chain[4];
    end
  end

  // Control state: chaining words, counters, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0]    <= sha1md_pkg::IV0;
      chain[1]    <= sha1md_pkg::IV1;
      chain[2]    <= sha1md_pkg::IV2;
      chain[3]    <= sha1md_pkg::IV3;
      chain[4]    <= sha1md_pkg::IV4;
      fill        <= '0;
      round_index <= '0;
      byte_count  <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.put_byte) begin
        fill <= fill + 1'b1;
        if (fill == sha1md_pkg::FILL_LAST) begin
          round_index <= '0;
        end
      end
      if (cmd.round_step) begin
        round_index <= round_index + 1'b1;
      end
      if (cmd.count_inc) begin
        byte_count <= byte_count + 1'b1;
      end
      if (cmd.chain_add) begin
        chain[0] <= chain[0] + va;
        chain[1] <= chain[1] + vb;
        chain[2] <= chain[2] + vc;
        chain[3] <= chain[3] + vd;
        chain[4] <= chain[4] + ve;
      end
      if (cmd.emit) begin
        // reload for the next message
        chain[0]   <= sha1md_pkg::IV0;
        chain[1]   <= sha1md_pkg::IV1;
        chain[2]   <= sha1md_pkg::IV2;
        chain[3]   <= sha1md_pkg::IV3;
        chain[4]   <= sha1md_pkg::IV4;
        byte_count <= '0;
        fill       <= '0;
        out_valid  <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// sha1_message_digest
// SHA-1 engine fed one message byte per item, giving the 160-bit digest.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while the engine is idle and are packed
// big-endian into a 64-byte block. A full block occupies the engine for
// 80 rounds on a single round unit plus a step that folds the result into
// the chaining words; no bytes are taken meanwhile. An item with last_byte
// set is followed by padding, written one byte per cycle into the block
// buffer, the compression of one or two blocks, and the loading of the
// digest register. The digest sits in an output register, so the next
// message may begin while it waits to be taken. byte_present low with
// last_byte high ends a message without adding a byte; both low is a no-op.
module sha1_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_present,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word_0,
  output logic [31:0] digest_word_1,
  output logic [31:0] digest_word_2,
  output logic [31:0] digest_word_3,
  output logic [31:0] digest_word_4
);

  sha1md_pkg::cmd_t    cmd;
  sha1md_pkg::status_t status;

  sha1md_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .byte_present (byte_present),
    .last_byte    (last_byte),
    .in_stall     (in_stall),
    .status       (status),
    .cmd          (cmd)
  );

  sha1md_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (data_byte),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .digest_word_0 (digest_word_0),
    .digest_word_1 (digest_word_1),
    .digest_word_2 (digest_word_2),
    .digest_word_3 (digest_word_3),
    .digest_word_4 (digest_word_4)
  );

endmodule
